FILE: hw/rtl/cbim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbim_pkg
// Shared types and constants for the cartridge bank and irq mapper.
// ----------------------------------------------------------------------------
package cbim_pkg;

    localparam int PATTERN_SLOTS = 8;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // board wiring variants, anything else decodes as VARIANT_A
    localparam logic [1:0] VARIANT_A = 2'd0;
    localparam logic [1:0] VARIANT_B = 2'd1;
    localparam logic [1:0] VARIANT_C = 2'd2;

    // 4K regions, address bits 15..12
    localparam logic [3:0] REGION_PRG_FIRST  = 4'h8;
    localparam logic [3:0] REGION_MIRROR     = 4'h9;
    localparam logic [3:0] REGION_PRG_SECOND = 4'hA;
    localparam logic [3:0] REGION_CHR_FIRST  = 4'hB;
    localparam logic [3:0] REGION_CHR_SECOND = 4'hC;
    localparam logic [3:0] REGION_CHR_THIRD  = 4'hD;
    localparam logic [3:0] REGION_CHR_FOURTH = 4'hE;
    localparam logic [3:0] REGION_IRQ        = 4'hF;

    // register selects inside the irq region
    localparam logic [1:0] SEL_LATCH_LO = 2'd0;
    localparam logic [1:0] SEL_LATCH_HI = 2'd1;
    localparam logic [1:0] SEL_CONTROL  = 2'd2;
    localparam logic [1:0] SEL_ACK      = 2'd3;

    // scanline prescaler: adds 3 per tick, wraps at 341
    localparam logic [8:0] PRESCALE_LIMIT = 9'd338;
    localparam logic [8:0] PRESCALE_STEP  = 9'd3;
    localparam logic [7:0] COUNTER_TOP    = 8'hFF;

    typedef struct packed {
        logic       prg_first_we;
        logic       prg_second_we;
        logic       mirror_we;
        logic       swap_we;
        logic       chr_we;
        logic       chr_hi;
        logic [2:0] chr_slot;
        logic       latch_lo_we;
        logic       latch_hi_we;
        logic       control_we;
        logic       ack_we;
        logic       tick;
        logic [7:0] data;
    } cmd_t;

endpackage

FILE: hw/rtl/cbim_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbim_decode
// Turns one registered bus write or tick into register update strobes.
// ----------------------------------------------------------------------------
module cbim_decode (
    input  logic                fire,
    input  logic [1:0]          variant,
    input  logic                opcode,
    input  logic [15:0]         bus_address,
    input  logic [7:0]          write_data,
    output cbim_pkg::cmd_t      cmd
);
    import cbim_pkg::*;

    logic [3:0] region;
    logic [3:0] chr_offset;
    logic [1:0] sel;
    logic [1:0] sel_swap;
    logic       is_write;

    assign region   = bus_address[15:12];
    assign is_write = fire && (opcode == OP_WRITE);
    assign sel_swap = {bus_address[0] | bus_address[2], bus_address[1] | bus_address[3]};
    assign chr_offset = region - REGION_CHR_FIRST;

    always_comb
    begin
        unique case (variant)
            VARIANT_B:
            begin
                sel = {bus_address[1] | bus_address[3] | bus_address[5] | bus_address[7],
                       bus_address[0] | bus_address[2] | bus_address[4] | bus_address[6]};
            end
            VARIANT_C:
            begin
                sel = sel_swap;
            end
            default:
            begin
                sel = {bus_address[2] | bus_address[7], bus_address[1] | bus_address[6]};
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.data     = write_data;
        cmd.tick     = fire && (opcode == OP_TICK);
        cmd.chr_hi   = sel[0];
        cmd.chr_slot = {chr_offset[1:0], sel[1]};
        if (is_write)
        begin
            unique case (region)
                REGION_PRG_FIRST:  cmd.prg_first_we  = 1'b1;
                REGION_PRG_SECOND: cmd.prg_second_we = 1'b1;
                REGION_MIRROR:
                begin
                    cmd.mirror_we = ~sel[1];
                    cmd.swap_we   = sel[1];
                end
                REGION_CHR_FIRST, REGION_CHR_SECOND, REGION_CHR_THIRD, REGION_CHR_FOURTH:
                begin
                    cmd.chr_we = 1'b1;
                end
                REGION_IRQ:
                begin
                    unique case (sel)
                        SEL_LATCH_LO: cmd.latch_lo_we = 1'b1;
                        SEL_LATCH_HI: cmd.latch_hi_we = 1'b1;
                        SEL_CONTROL:  cmd.control_we  = 1'b1;
                        default:      cmd.ack_we      = 1'b1;
                    endcase
                end
                default:
                begin
                    // low address space, nothing mapped
                    cmd.prg_first_we = 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/cbim_banks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbim_banks
// PRG and CHR bank registers, swap mode and mirroring.
// ----------------------------------------------------------------------------
module cbim_banks (
    input  logic            clk,
    input  logic            rst_n,
    input  cbim_pkg::cmd_t  cmd,
    output logic            prg_swap_mode,
    output logic [7:0]      prg_bank_first,
    output logic [7:0]      prg_bank_second,
    output logic [1:0]      mirroring,
    output logic [2:0]      chr_slot,
    output logic [7:0]      chr_bank
);
    import cbim_pkg::*;

    logic       swap_reg;
    logic [7:0] first_reg;
    logic [7:0] second_reg;
    logic [1:0] mirror_reg;
    logic [2:0] last_slot_reg;
    // nibbles kept apart so a write never needs the old byte
    logic [3:0] chr_lo_reg [PATTERN_SLOTS];
    logic [3:0] chr_hi_reg [PATTERN_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg      <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            mirror_reg    <= '0;
            last_slot_reg <= '0;
            for (int i = 0; i < PATTERN_SLOTS; i++)
            begin
                chr_lo_reg[i] <= '0;
                chr_hi_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.prg_first_we)
                first_reg <= cmd.data;
            if (cmd.prg_second_we)
                second_reg <= cmd.data;
            if (cmd.mirror_we)
                mirror_reg <= cmd.data[1:0];
            if (cmd.swap_we)
                swap_reg <= cmd.data[1];
            if (cmd.chr_we)
            begin
                last_slot_reg <= cmd.chr_slot;
                if (cmd.chr_hi)
                    chr_hi_reg[cmd.chr_slot] <= cmd.data[3:0];
                else
                    chr_lo_reg[cmd.chr_slot] <= cmd.data[3:0];
            end
        end
    end

    assign prg_swap_mode   = swap_reg;
    assign prg_bank_first  = first_reg;
    assign prg_bank_second = second_reg;
    assign mirroring       = mirror_reg;
    assign chr_slot        = last_slot_reg;
    assign chr_bank        = {chr_hi_reg[last_slot_reg], chr_lo_reg[last_slot_reg]};

endmodule

FILE: hw/rtl/cbim_irq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbim_irq
// IRQ latch, prescaler, 8-bit up-counter and sticky request.
// ----------------------------------------------------------------------------
module cbim_irq (
    input  logic            clk,
    input  logic            rst_n,
    input  cbim_pkg::cmd_t  cmd,
    output logic            irq_line
);
    import cbim_pkg::*;

    logic [1:0] control_reg,   control_next;
    logic       enabled_reg,   enabled_next;
    logic [7:0] latch_reg,     latch_next;
    logic [8:0] prescaler_reg, prescaler_next;
    logic [7:0] counter_reg,   counter_next;
    logic       pending_reg,   pending_next;
    logic       clock_counter;

    always_comb
    begin
        control_next   = control_reg;
        enabled_next   = enabled_reg;
        latch_next     = latch_reg;
        prescaler_next = prescaler_reg;
        counter_next   = counter_reg;
        pending_next   = pending_reg;
        clock_counter  = 1'b0;

        if (cmd.latch_lo_we)
            latch_next = {latch_reg[7:4], cmd.data[3:0]};
        if (cmd.latch_hi_we)
            latch_next = {cmd.data[3:0], latch_reg[3:0]};
        if (cmd.control_we)
        begin
            control_next = {cmd.data[2], cmd.data[0]};
            enabled_next = cmd.data[1];
            pending_next = 1'b0;
            if (cmd.data[1])
            begin
                prescaler_next = '0;
                counter_next   = latch_reg;
            end
        end
        if (cmd.ack_we)
        begin
            enabled_next = control_reg[0];
            pending_next = 1'b0;
        end

        if (cmd.tick && enabled_reg)
        begin
            // bit 1 of control selects cycle mode, no prescaling
            if (control_reg[1])
                clock_counter = 1'b1;
            else if (prescaler_reg < PRESCALE_LIMIT)
                prescaler_next = prescaler_reg + PRESCALE_STEP;
            else
            begin
                prescaler_next = prescaler_reg - PRESCALE_LIMIT;
                clock_counter  = 1'b1;
            end
        end

        if (clock_counter)
        begin
            if (counter_reg != COUNTER_TOP)
                counter_next = counter_reg + 8'd1;
            else
            begin
                counter_next = latch_reg;
                pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= '0;
            enabled_reg   <= 1'b0;
            latch_reg     <= '0;
            prescaler_reg <= '0;
            counter_reg   <= '0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            control_reg   <= control_next;
            enabled_reg   <= enabled_next;
            latch_reg     <= latch_next;
            prescaler_reg <= prescaler_next;
            counter_reg   <= counter_next;
            pending_reg   <= pending_next;
        end
    end

    assign irq_line = pending_reg;

endmodule

FILE: hw/rtl/cartridge_bank_irq_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_irq_mapper_unit
// Mapper register block: bank registers, mirroring and scanline/cycle IRQ.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless stalled, either a CPU bus write or
// one CPU cycle tick, and answers each with one transaction carrying the full
// mapper state after that item. An accepted item waits in the input register
// until the result slot frees, is then decoded and applied to the state
// registers, and its result is valid from then on. The state registers double
// as the result register, so a stalled result holds while the next item waits
// in the input register.
// wiring_variant may only be written while no transaction is in flight.
module cartridge_bank_irq_mapper_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  wiring_variant,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        irq_line,
    output logic        prg_swap_mode,
    output logic [7:0]  prg_bank_first,
    output logic [7:0]  prg_bank_second,
    output logic [1:0]  mirroring,
    output logic [2:0]  chr_slot,
    output logic [7:0]  chr_bank
);
    import cbim_pkg::*;

    logic        variant_reg;
    logic [1:0]  variant_value_reg;
    logic        in_valid_reg,  in_valid_next;
    logic        opcode_reg;
    logic [15:0] address_reg;
    logic [7:0]  data_reg;
    logic        out_valid_reg, out_valid_next;
    logic        advance;
    logic        in_take;
    cmd_t        cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg       <= 1'b0;
            variant_value_reg <= VARIANT_A;
        end
        else if (cfg_valid && cfg_ready)
        begin
            variant_reg       <= 1'b1;
            variant_value_reg <= wiring_variant;
        end
    end

    // the result slot frees when empty or when its transaction is taken
    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && !advance;
    assign in_take        = in_valid && !in_stall;
    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            opcode_reg  <= opcode;
            address_reg <= bus_address;
            data_reg    <= write_data;
        end
    end

    cbim_decode u_decode (
        .fire        (advance),
        .variant     (variant_reg ? variant_value_reg : VARIANT_A),
        .opcode      (opcode_reg),
        .bus_address (address_reg),
        .write_data  (data_reg),
        .cmd         (cmd)
    );

    cbim_banks u_banks (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .prg_swap_mode   (prg_swap_mode),
        .prg_bank_first  (prg_bank_first),
        .prg_bank_second (prg_bank_second),
        .mirroring       (mirroring),
        .chr_slot        (chr_slot),
        .chr_bank        (chr_bank)
    );

    cbim_irq u_irq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .irq_line (irq_line)
    );

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with an empty input register");

    a_irq_set_by_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (irq_line && !$past(irq_line)) |-> $past(advance && (opcode_reg == OP_TICK)))
        else $error("irq raised without an applied tick");

    a_irq_clear_by_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!irq_line && $past(irq_line)) |-> $past(advance && (opcode_reg == OP_WRITE)))
        else $error("irq cleared without an applied bus write");

    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> ($stable(chr_bank) && $stable(irq_line)))
        else $error("mapper state changed without an applied transaction");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cartridge bank and irq mapper unit.
// ----------------------------------------------------------------------------
// A queue of CPU bus writes and cycle ticks feeds a bursty driver. A mirror of
// the mapper registers and the irq unit predicts the visible state after every
// accepted transaction. The monitor checks each result against the oldest
// prediction. The run steps through every board wiring variant. It starts
// with directed writes and then moves to irq sequences with random content,
// mixed with random writes and ticks. The output side stalls in shifting
// patterns and once holds off long enough to back up the input.
module tb_top;
    import cbim_pkg::*;

    localparam logic [1:0] VARIANT_UNUSED = 2'd3;
    localparam int SQUEEZE_CYCLES = 64;
    localparam int TAIL_CYCLES = 10;

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
    } bus_item_t;

    typedef struct packed {
        logic       irq;
        logic       swap;
        logic [7:0] first;
        logic [7:0] second;
        logic [1:0] mirror;
        logic [2:0] slot;
        logic [7:0] chr;
    } mapper_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  wiring_variant = VARIANT_A;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = OP_WRITE;
    logic [15:0] bus_address = '0;
    logic [7:0]  write_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        irq_line;
    logic        prg_swap_mode;
    logic [7:0]  prg_bank_first;
    logic [7:0]  prg_bank_second;
    logic [1:0]  mirroring;
    logic [2:0]  chr_slot;
    logic [7:0]  chr_bank;

    cartridge_bank_irq_mapper_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .wiring_variant  (wiring_variant),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .bus_address     (bus_address),
        .write_data      (write_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .irq_line        (irq_line),
        .prg_swap_mode   (prg_swap_mode),
        .prg_bank_first  (prg_bank_first),
        .prg_bank_second (prg_bank_second),
        .mirroring       (mirroring),
        .chr_slot        (chr_slot),
        .chr_bank        (chr_bank)
    );

    bus_item_t    pending_items[$];
    mapper_view_t expected_views[$];

    // mirror of the mapper state
    logic [1:0] cur_variant = VARIANT_A;
    logic       m_swap = 1'b0;
    logic [7:0] m_first = '0;
    logic [7:0] m_second = '0;
    logic [1:0] m_mirror = '0;
    logic [7:0] m_chr [PATTERN_SLOTS] = '{default: '0};
    logic [2:0] m_slot = '0;
    logic [1:0] m_control = '0;
    logic       m_enabled = 1'b0;
    logic [7:0] m_latch = '0;
    logic [8:0] m_prescale = '0;
    logic [7:0] m_counter = '0;
    logic       m_pending = 1'b0;

    int fail_count = 0;
    int items_queued = 0;
    int writes_sent = 0;
    int ticks_sent = 0;
    int results_checked = 0;
    int irq_raised = 0;

    // driver and receiver control
    bus_item_t driven;
    int  burst_left = 1;
    int  gap_left = 0;
    logic steady_send = 1'b0;
    logic squeeze_armed = 1'b0;
    logic squeeze_done = 1'b0;
    int  squeeze_count = 0;
    int  stall_mode = 0;
    int  stall_left = 0;
    int  stall_phase = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [1:0] decode_sel(input logic [1:0] variant,
                                              input logic [15:0] a);
        logic [15:0] s;
        case (variant)
            VARIANT_B: s = a | (a >> 2) | (a >> 4) | (a >> 6);
            VARIANT_C:
            begin
                s = a | (a >> 2);
                s = {14'd0, s[0], s[1]};
            end
            default: s = (a >> 1) | (a >> 6);
        endcase
        return s[1:0];
    endfunction

    // address in a region that decodes to sel under the current wiring
    function automatic logic [15:0] reg_address(input logic [3:0] region,
                                                input logic [1:0] sel);
        logic [15:0] a;
        a = {region, 4'($urandom), 8'd0};
        case (cur_variant)
            VARIANT_B: a[1:0] = sel;
            VARIANT_C: a[1:0] = {sel[0], sel[1]};
            default:   a[2:1] = sel;
        endcase
        return a;
    endfunction

    task automatic apply_mapper_item(input bus_item_t it, output mapper_view_t v);
        logic [3:0] region;
        logic [3:0] rel;
        logic [1:0] sel;
        logic [2:0] slot;
        logic       was_pending;
        was_pending = m_pending;
        region = it.addr[15:12];
        sel = decode_sel(cur_variant, it.addr);
        if (it.op == OP_TICK)
        begin
            writes_sent = writes_sent;
            ticks_sent++;
            if (m_enabled)
            begin
                if (!m_control[1] && m_prescale < PRESCALE_LIMIT)
                    m_prescale = m_prescale + PRESCALE_STEP;
                else
                begin
                    if (!m_control[1])
                        m_prescale = m_prescale - PRESCALE_LIMIT;
                    if (m_counter != COUNTER_TOP)
                        m_counter = m_counter + 8'd1;
                    else
                    begin
                        m_counter = m_latch;
                        m_pending = 1'b1;
                    end
                end
            end
        end
        else
        begin
            writes_sent++;
            if (region == REGION_PRG_FIRST)
                m_first = it.data;
            else if (region == REGION_PRG_SECOND)
                m_second = it.data;
            else if (region == REGION_MIRROR)
            begin
                if (!sel[1])
                    m_mirror = it.data[1:0];
                else
                    m_swap = it.data[1];
            end
            else if (region >= REGION_CHR_FIRST && region <= REGION_CHR_FOURTH)
            begin
                rel = region - REGION_CHR_FIRST;
                slot = {rel[1:0], sel[1]};
                if (sel[0])
                    m_chr[slot][7:4] = it.data[3:0];
                else
                    m_chr[slot][3:0] = it.data[3:0];
                m_slot = slot;
            end
            else if (region == REGION_IRQ)
            begin
                case (sel)
                    SEL_LATCH_LO: m_latch[3:0] = it.data[3:0];
                    SEL_LATCH_HI: m_latch[7:4] = it.data[3:0];
                    SEL_CONTROL:
                    begin
                        m_control = {it.data[2], it.data[0]};
                        m_enabled = it.data[1];
                        if (m_enabled)
                        begin
                            m_prescale = '0;
                            m_counter = m_latch;
                        end
                        m_pending = 1'b0;
                    end
                    default:
                    begin
                        m_enabled = m_control[0];
                        m_pending = 1'b0;
                    end
                endcase
            end
            // writes below 0x8000 fall through untouched
        end
        if (m_pending && !was_pending)
            irq_raised++;
        v.irq = m_pending;
        v.swap = m_swap;
        v.first = m_first;
        v.second = m_second;
        v.mirror = m_mirror;
        v.slot = m_slot;
        v.chr = m_chr[m_slot];
    endtask

    // driver: bursts of transactions with random gaps
    always @(posedge clk)
    begin
        mapper_view_t v;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                apply_mapper_item(driven, v);
                expected_views.push_back(v);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0 && !steady_send)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    driven = pending_items.pop_front();
                    opcode <= driven.op;
                    bus_address <= driven.addr;
                    write_data <= driven.data;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: shifting patterns, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (squeeze_armed && !squeeze_done)
            begin
                out_stall <= 1'b1;
                squeeze_count++;
                if (squeeze_count >= SQUEEZE_CYCLES)
                    squeeze_done = 1'b1;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    stall_left = $urandom_range(20, 120);
                end
                stall_left--;
                stall_phase++;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    default: out_stall <= ((stall_phase % 7) < 3);
                endcase
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        mapper_view_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_views.size() == 0)
            begin
                $error("result transaction with no prediction waiting");
                fail_count++;
            end
            else
            begin
                e = expected_views.pop_front();
                results_checked++;
                check_field("irq_line", e.irq, irq_line);
                check_field("prg_swap_mode", e.swap, prg_swap_mode);
                check_field("prg_bank_first", e.first, prg_bank_first);
                check_field("prg_bank_second", e.second, prg_bank_second);
                check_field("mirroring", e.mirror, mirroring);
                check_field("chr_slot", e.slot, chr_slot);
                check_field("chr_bank", e.chr, chr_bank);
            end
        end
    end

    task automatic queue_item(input logic op, input logic [15:0] a, input logic [7:0] d);
        bus_item_t it;
        it.op = op;
        it.addr = a;
        it.data = d;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_tick();
        queue_item(OP_TICK, 16'($urandom), 8'($urandom));
    endtask

    task automatic queue_random_write();
        logic [15:0] a;
        if ($urandom_range(0, 3) == 0)
            a = 16'($urandom);
        else
            a = reg_address(4'($urandom_range(8, 15)), 2'($urandom));
        queue_item(OP_WRITE, a, 8'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_views.size() != 0)
            @(posedge clk);
    endtask

    task automatic config_write(input logic [1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        wiring_variant <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_variant = v;
    endtask

    task automatic directed_items();
        queue_item(OP_WRITE, 16'h0000, 8'hFF);   // low address, ignored
        queue_item(OP_WRITE, 16'h7FFF, 8'hFF);
        queue_item(OP_WRITE, reg_address(REGION_PRG_FIRST, 2'd0), 8'hFF);
        queue_item(OP_WRITE, 16'hAFFF, 8'h80);
        queue_item(OP_WRITE, reg_address(REGION_MIRROR, SEL_LATCH_LO), 8'h03);
        queue_item(OP_WRITE, reg_address(REGION_MIRROR, SEL_CONTROL), 8'h02);
        queue_item(OP_WRITE, reg_address(REGION_CHR_FIRST, 2'd0), 8'h0F);
        queue_item(OP_WRITE, reg_address(REGION_CHR_FIRST, 2'd1), 8'hFA);
        queue_item(OP_WRITE, reg_address(REGION_CHR_SECOND, 2'd2), 8'h05);
        queue_item(OP_WRITE, reg_address(REGION_CHR_THIRD, 2'd3), 8'hF0);
        queue_item(OP_WRITE, reg_address(REGION_CHR_FOURTH, 2'd3), 8'hFF);
        queue_tick();                            // tick while disabled
        // latch 0xFE, cycle mode, re-enable on acknowledge
        queue_item(OP_WRITE, reg_address(REGION_IRQ, SEL_LATCH_LO), 8'h0E);
        queue_item(OP_WRITE, reg_address(REGION_IRQ, SEL_LATCH_HI), 8'hFF);
        queue_item(OP_WRITE, reg_address(REGION_IRQ, SEL_CONTROL), 8'h07);
        queue_tick();
        queue_tick();                            // counter wraps, irq raised
        queue_tick();
        queue_item(OP_WRITE, reg_address(REGION_IRQ, SEL_ACK), 8'h00);
        // scanline mode
        queue_item(OP_WRITE, reg_address(REGION_IRQ, SEL_CONTROL), 8'h02);
        repeat (4) queue_tick();
        queue_item(OP_WRITE, 16'hFFFF, 8'h00);   // acknowledge, disables
    endtask

    task automatic random_items(input int n);
        int start;
        int len;
        logic cycle_mode;
        logic [3:0] lo;
        logic [3:0] hi;
        logic [7:0] ctl;
        start = items_queued;
        while (items_queued - start < n)
        begin
            case ($urandom_range(0, 99) / 35)
                0:
                begin
                    // irq sequence: latch, control, ticks, maybe acknowledge
                    cycle_mode = 1'($urandom);
                    lo = ($urandom_range(0, 9) < 7) ? 4'hF : 4'($urandom);
                    hi = ($urandom_range(0, 9) < 8) ? 4'hF : 4'($urandom);
                    queue_item(OP_WRITE, reg_address(REGION_IRQ, SEL_LATCH_LO),
                               {4'($urandom), lo});
                    queue_item(OP_WRITE, reg_address(REGION_IRQ, SEL_LATCH_HI),
                               {4'($urandom), hi});
                    ctl = 8'($urandom);
                    ctl[2] = cycle_mode;
                    if ($urandom_range(0, 99) < 85)
                        ctl[1] = 1'b1;
                    queue_item(OP_WRITE, reg_address(REGION_IRQ, SEL_CONTROL), ctl);
                    len = cycle_mode ? $urandom_range(1, 40) : $urandom_range(20, 200);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 19) == 0)
                            queue_random_write();
                        else
                            queue_tick();
                    end
                    if ($urandom_range(0, 99) < 60)
                        queue_item(OP_WRITE, reg_address(REGION_IRQ, SEL_ACK),
                                   8'($urandom));
                end
                1: queue_random_write();
                default: repeat ($urandom_range(1, 8)) queue_tick();
            endcase
        end
    endtask

    initial begin
        logic [1:0] plan [7];
        plan = '{VARIANT_A, VARIANT_C, VARIANT_B, VARIANT_UNUSED,
                 VARIANT_C, VARIANT_B, VARIANT_A};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 7; p++)
        begin
            wait_drained();
            config_write(plan[p]);
            steady_send = (p == 1);
            if (p == 0)
                directed_items();
            if (p == 1)
                squeeze_armed = 1'b1;   // output holds off while input keeps coming
            if (p == 3)
            begin
                random_items(120);
                wait_drained();         // sender pauses until all results are in
                random_items(120);
            end
            else
                random_items(240);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d transactions (%0d bus writes, %0d ticks) over wiring variants 0-3",
                 writes_sent + ticks_sent, writes_sent, ticks_sent);
        $display("%0d results compared, %0d interrupt requests raised",
                 results_checked, irq_raised);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
